// ----- hw/rtl/cheapest_slot_selector_macros.svh -----
// Assertion macros for the cheapest slot selector.
// Included by the RTL files that carry concurrent checks; no other dependencies.
`ifndef CHEAPEST_SLOT_SELECTOR_MACROS_SVH
`define CHEAPEST_SLOT_SELECTOR_MACROS_SVH

// check a property on every rising clock edge outside reset
`define CSS_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// check that a condition implies a property in the next cycle
`define CSS_ASSERT_NEXT(label, clk, rst, cond, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ----- hw/rtl/css_pkg.sv -----
// Shared types and constants for the cheapest slot selector.
// Used by css_entry_store, css_cell and cheapest_slot_selector; no dependencies.
`timescale 1ns / 1ps

package css_pkg;

   localparam int MAX_ENTRIES   = 64;
   localparam int ADDR_W        = $clog2(MAX_ENTRIES);
   localparam int COUNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int CALC_W        = COUNT_W + 2;
   localparam int HOURS_PER_DAY = 24;
   localparam int MAX_PICKS     = 8;
   localparam int CELL_COUNT    = MAX_PICKS - 1;
   localparam int CELL_IDX_W    = $clog2(CELL_COUNT);
   localparam int SLOT_W        = $clog2(MAX_PICKS + 1);
   localparam int PICK_W        = $clog2(MAX_PICKS);
   localparam int DRAIN_CYCLES  = CELL_COUNT + 2;
   localparam int DRAIN_W       = $clog2(DRAIN_CYCLES);

   localparam int HOUR_W  = 5;
   localparam int PRICE_W = 24;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 5;
   localparam int SLOTS_W     = 4;

   localparam logic [CSR_INDEX_W-1:0] CSR_CHARGE_SLOTS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_CUTOFF_HOUR  = 2'd1;

   localparam logic [SLOTS_W-1:0] CHARGE_SLOTS_RESET = 4'd4;
   localparam logic [HOUR_W-1:0]  CUTOFF_HOUR_RESET  = 5'd7;

   typedef struct packed {
      logic [HOUR_W-1:0]         hour;
      logic signed [PRICE_W-1:0] price;
      logic                      is_final;
   } css_req_type;

   typedef struct packed {
      logic [HOUR_W-1:0]         slot_hour;
      logic signed [PRICE_W-1:0] slot_price;
      logic                      end_of_run;
   } css_rsp_type;

   typedef struct packed {
      logic [HOUR_W-1:0]         hour;
      logic signed [PRICE_W-1:0] price;
   } css_entry_type;

   typedef struct packed {
      logic          valid;
      css_entry_type entry;
   } css_link_type;

   typedef enum logic [4:0] {
      ST_LOAD   = 5'b00001,
      ST_WINDOW = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_DRAIN  = 5'b01000,
      ST_EMIT   = 5'b10000
   } css_state_type;

endpackage

// ----- hw/rtl/css_entry_store.sv -----
// Entry memory: one write port, one registered read port.
// Depends on css_pkg.
`timescale 1ns / 1ps

module css_entry_store (
   input  logic                          clock,
   input  logic                          wr_en,
   input  logic [css_pkg::ADDR_W-1:0]    wr_addr,
   input  css_pkg::css_entry_type        wr_data,
   input  logic                          rd_en,
   input  logic [css_pkg::ADDR_W-1:0]    rd_addr,
   output css_pkg::css_entry_type        rd_data
);

   css_pkg::css_entry_type entry_mem_ff [0:css_pkg::MAX_ENTRIES-1];
   css_pkg::css_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entry_mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entry_mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- hw/rtl/css_cell.sv -----
// One cell of the sorting chain: holds the lowest distinct price seen so far,
// passes larger or displaced entries on, drops repeats. Depends on css_pkg.
`timescale 1ns / 1ps

module css_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  clear,
   input  css_pkg::css_link_type in_link,
   output css_pkg::css_link_type held,
   output css_pkg::css_link_type out_link
);

   css_pkg::css_link_type held_ff, held_in;
   css_pkg::css_link_type out_ff, out_in;

   always_comb begin
      held_in      = held_ff;
      out_in       = in_link;
      out_in.valid = 1'b0;
      if (clear) begin
         held_in.valid = 1'b0;
      end else if (in_link.valid) begin
         if (!held_ff.valid) begin
            held_in = in_link;
         end else if (in_link.entry.price < held_ff.entry.price) begin
            held_in = in_link;
            out_in  = held_ff;
         end else if (in_link.entry.price != held_ff.entry.price) begin
            out_in = in_link;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff.valid <= 1'b0;
         out_ff.valid  <= 1'b0;
      end else begin
         held_ff.valid <= held_in.valid;
         out_ff.valid  <= out_in.valid;
      end
      held_ff.entry <= held_in.entry;
      out_ff.entry  <= out_in.entry;
   end

   assign held     = held_ff;
   assign out_link = out_ff;

endmodule

// ----- hw/rtl/cheapest_slot_selector.sv -----
// Cheapest slot selector top level: load, window, scan through the cell chain, emit.
// Depends on css_pkg, css_entry_store, css_cell and cheapest_slot_selector_macros.svh.
//
// Usage:
//   Price entries arrive on req_data and are taken at each clock edge with start
//   high and busy low. A non-final entry gives no result and leaves busy low, so
//   entries load at one per cycle. An entry with is_final set ends the data set:
//   busy rises and the block computes the picks, then emits charge_slots results
//   (clamped to 1 to 8) on rsp_data, one per cycle, each marked by rsp_strobe for
//   one cycle; the last carries end_of_run. The receiver cannot hold results off.
//   After the final entry the block sets the window length W; the scan then reads the
//   first W stored entries, one per cycle, through the single memory read port and
//   streams them into a chain of seven sorting cells, which then settle before the
//   picks are read out. busy drops with the last result, and a new data set may
//   start in that cycle.
//   Registers are written on csr_*: index 0 charge_slots, index 1 cutoff_hour;
//   other indexes are ignored; csr_ready is always high.
//   Synchronous reset empties the store, returns the registers to 4 and 7 and
//   leaves the block idle. No clearing pass is needed.
`timescale 1ns / 1ps
`include "cheapest_slot_selector_macros.svh"

module cheapest_slot_selector (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  css_pkg::css_req_type             req_data,
   output logic                             rsp_strobe,
   output css_pkg::css_rsp_type             rsp_data,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [css_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [css_pkg::CSR_DATA_W-1:0]   csr_data
);

   css_pkg::css_state_type state_ff, state_in;

   logic [css_pkg::COUNT_W-1:0]  count_ff, count_in;
   logic [css_pkg::HOUR_W-1:0]   first_hour_ff, first_hour_in;
   css_pkg::css_entry_type       min_ff, min_in;
   css_pkg::css_entry_type       max_ff, max_in;
   logic [css_pkg::SLOTS_W-1:0]  charge_slots_ff, charge_slots_in;
   logic [css_pkg::HOUR_W-1:0]   cutoff_ff, cutoff_in;
   logic [css_pkg::COUNT_W-1:0]  win_ff, win_in;
   logic [css_pkg::COUNT_W-1:0]  scan_ff, scan_in;
   logic                         rd_valid_ff, rd_valid_in;
   logic [css_pkg::DRAIN_W-1:0]  drain_ff, drain_in;
   logic [css_pkg::PICK_W-1:0]   pick_ff, pick_in;
   logic                         rsp_strobe_ff, rsp_strobe_in;
   css_pkg::css_rsp_type         rsp_ff, rsp_in;

   logic                         accept;
   logic                         has_room;
   logic                         wr_en;
   logic                         rd_en;
   css_pkg::css_entry_type       new_entry;
   css_pkg::css_entry_type       rd_entry;
   logic signed [css_pkg::CALC_W-1:0] win_calc;
   logic [css_pkg::SLOT_W-1:0]   slots_eff;
   logic [css_pkg::PICK_W-1:0]   last_pick;
   logic [css_pkg::CELL_IDX_W-1:0] cell_sel;
   logic                         cell_clear;
   css_pkg::css_link_type        feed;
   css_pkg::css_link_type        cell_held [0:css_pkg::CELL_COUNT-1];
   css_pkg::css_link_type        cell_out  [0:css_pkg::CELL_COUNT-1];
   css_pkg::css_entry_type       pick_entry;

   assign busy      = (state_ff != css_pkg::ST_LOAD);
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign has_room  = (count_ff < css_pkg::COUNT_W'(css_pkg::MAX_ENTRIES));
   assign wr_en     = accept && has_room;
   assign rd_en     = (state_ff == css_pkg::ST_SCAN) && (scan_ff < win_ff);
   assign cell_clear = (state_ff == css_pkg::ST_WINDOW);

   assign new_entry.hour  = req_data.hour;
   assign new_entry.price = req_data.price;

   css_entry_store u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[css_pkg::ADDR_W-1:0]),
      .wr_data (new_entry),
      .rd_en   (rd_en),
      .rd_addr (scan_ff[css_pkg::ADDR_W-1:0]),
      .rd_data (rd_entry)
   );

   // pass only prices strictly between the extremes into the chain
   always_comb begin
      feed.entry = rd_entry;
      feed.valid = rd_valid_ff && (rd_entry.price > min_ff.price)
                   && (rd_entry.price < max_ff.price);
   end

   genvar gi;
   generate
      for (gi = 0; gi < css_pkg::CELL_COUNT; gi++) begin : g_cell
         if (gi == 0) begin : g_head
            css_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .clear    (cell_clear),
               .in_link  (feed),
               .held     (cell_held[gi]),
               .out_link (cell_out[gi])
            );
         end else begin : g_body
            css_cell u_cell (
               .clock    (clock),
               .reset    (reset),
               .clear    (cell_clear),
               .in_link  (cell_out[gi-1]),
               .held     (cell_held[gi]),
               .out_link (cell_out[gi])
            );
         end
      end
   endgenerate

   always_comb begin
      if (charge_slots_ff == '0) begin
         slots_eff = css_pkg::SLOT_W'(1);
      end else if (css_pkg::SLOT_W'(charge_slots_ff) > css_pkg::SLOT_W'(css_pkg::MAX_PICKS)) begin
         slots_eff = css_pkg::SLOT_W'(css_pkg::MAX_PICKS);
      end else begin
         slots_eff = css_pkg::SLOT_W'(charge_slots_ff);
      end
   end

   assign last_pick = css_pkg::PICK_W'(slots_eff - css_pkg::SLOT_W'(1));
   assign cell_sel  = css_pkg::CELL_IDX_W'(pick_ff - css_pkg::PICK_W'(1));

   always_comb begin
      if (cutoff_ff >= first_hour_ff) begin
         win_calc = css_pkg::CALC_W'(cutoff_ff) - css_pkg::CALC_W'(first_hour_ff);
      end else begin
         win_calc = css_pkg::CALC_W'(css_pkg::HOURS_PER_DAY)
                    - css_pkg::CALC_W'(first_hour_ff) + css_pkg::CALC_W'(cutoff_ff);
      end
      if (win_calc[css_pkg::CALC_W-1]) begin
         win_in = '0;
      end else if ($unsigned(win_calc) > css_pkg::CALC_W'(count_ff)) begin
         win_in = count_ff;
      end else begin
         win_in = css_pkg::COUNT_W'($unsigned(win_calc));
      end
   end

   always_comb begin
      if (pick_ff == '0) begin
         pick_entry = min_ff;
      end else if (cell_held[cell_sel].valid) begin
         pick_entry = cell_held[cell_sel].entry;
      end else begin
         pick_entry = max_ff;
      end
   end

   always_comb begin
      charge_slots_in = charge_slots_ff;
      cutoff_in       = cutoff_ff;
      if (csr_valid && csr_ready) begin
         case (csr_index)
            css_pkg::CSR_CHARGE_SLOTS: charge_slots_in = csr_data[css_pkg::SLOTS_W-1:0];
            css_pkg::CSR_CUTOFF_HOUR:  cutoff_in       = csr_data[css_pkg::HOUR_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      first_hour_in = first_hour_ff;
      min_in        = min_ff;
      max_in        = max_ff;
      scan_in       = scan_ff;
      rd_valid_in   = rd_en;
      drain_in      = drain_ff;
      pick_in       = pick_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      case (state_ff)
         css_pkg::ST_LOAD: begin
            if (accept) begin
               if (has_room) begin
                  count_in = count_ff + css_pkg::COUNT_W'(1);
                  if (count_ff == '0) begin
                     first_hour_in = req_data.hour;
                     min_in        = new_entry;
                     max_in        = new_entry;
                  end else if (req_data.price > max_ff.price) begin
                     max_in = new_entry;
                  end else if (req_data.price < min_ff.price) begin
                     min_in = new_entry;
                  end
               end
               if (req_data.is_final) begin
                  state_in = css_pkg::ST_WINDOW;
               end
            end
         end
         css_pkg::ST_WINDOW: begin
            scan_in  = '0;
            state_in = css_pkg::ST_SCAN;
         end
         css_pkg::ST_SCAN: begin
            if (rd_en) begin
               scan_in = scan_ff + css_pkg::COUNT_W'(1);
            end else begin
               drain_in = '0;
               state_in = css_pkg::ST_DRAIN;
            end
         end
         css_pkg::ST_DRAIN: begin
            drain_in = drain_ff + css_pkg::DRAIN_W'(1);
            if (drain_ff == css_pkg::DRAIN_W'(css_pkg::DRAIN_CYCLES - 1)) begin
               pick_in  = '0;
               state_in = css_pkg::ST_EMIT;
            end
         end
         css_pkg::ST_EMIT: begin
            rsp_strobe_in     = 1'b1;
            rsp_in.slot_hour  = pick_entry.hour;
            rsp_in.slot_price = pick_entry.price;
            rsp_in.end_of_run = (pick_ff == last_pick);
            pick_in           = pick_ff + css_pkg::PICK_W'(1);
            if (pick_ff == last_pick) begin
               count_in = '0;
               state_in = css_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = css_pkg::ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= css_pkg::ST_LOAD;
         count_ff        <= '0;
         charge_slots_ff <= css_pkg::CHARGE_SLOTS_RESET;
         cutoff_ff       <= css_pkg::CUTOFF_HOUR_RESET;
         rd_valid_ff     <= 1'b0;
         rsp_strobe_ff   <= 1'b0;
         scan_ff         <= '0;
         drain_ff        <= '0;
         pick_ff         <= '0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         charge_slots_ff <= charge_slots_in;
         cutoff_ff       <= cutoff_in;
         rd_valid_ff     <= rd_valid_in;
         rsp_strobe_ff   <= rsp_strobe_in;
         scan_ff         <= scan_in;
         drain_ff        <= drain_in;
         pick_ff         <= pick_in;
      end
      first_hour_ff <= first_hour_in;
      min_ff        <= min_in;
      max_ff        <= max_in;
      rsp_ff        <= rsp_in;
      if (state_ff == css_pkg::ST_WINDOW) begin
         win_ff <= win_in;
      end
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   `CSS_ASSERT(a_count_bound, clock, reset,
      count_ff <= css_pkg::COUNT_W'(css_pkg::MAX_ENTRIES), "entry count overflow")
   `CSS_ASSERT(a_rsp_while_busy, clock, reset,
      !rsp_strobe || $past(busy), "result strobe without a busy run")
   `CSS_ASSERT(a_pick_bound, clock, reset,
      state_ff != css_pkg::ST_EMIT || pick_ff <= last_pick, "pick index past slot count")
   `CSS_ASSERT(a_cells_sorted, clock, reset,
      !(cell_held[0].valid && cell_held[1].valid)
      || (cell_held[0].entry.price < cell_held[1].entry.price), "cell chain out of order")
   `CSS_ASSERT(a_tail_full, clock, reset,
      !cell_out[css_pkg::CELL_COUNT-1].valid || cell_held[css_pkg::CELL_COUNT-1].valid,
      "chain overflow with an empty tail cell")
   `CSS_ASSERT_NEXT(a_run_ends, clock, reset,
      rsp_strobe && rsp_data.end_of_run, !rsp_strobe, "result after end of run")

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for cheapest_slot_selector: price data sets, register writes,
// and an in-order check of every charging slot pick. Depends on css_pkg and the block RTL.

module testbench;
   import css_pkg::*;

   localparam int CLOCK_PERIOD  = 20;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int IDLE_GUARD    = 4;
   localparam int SETTLE_CYCLES = 100;
   localparam int RANDOM_ITEMS  = 250;
   localparam int PHASE_ITEMS   = 60;
   localparam int REPORT_LIMIT  = 10;

   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED_HI = 2'd3;

   localparam logic signed [PRICE_W-1:0] PRICE_LOWEST  = {1'b1, {(PRICE_W-1){1'b0}}};
   localparam logic signed [PRICE_W-1:0] PRICE_HIGHEST = {1'b0, {(PRICE_W-1){1'b1}}};

   typedef enum logic [1:0] {PRICES_WIDE, PRICES_NARROW, PRICES_EDGES} price_mix_type;

   logic                   clock;
   logic                   reset;
   logic                   start;
   logic                   busy;
   css_req_type            req_data;
   logic                   rsp_strobe;
   css_rsp_type            rsp_data;
   logic                   csr_valid;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_data;

   logic signed [PRICE_W-1:0] day_price [MAX_ENTRIES];
   logic [HOUR_W-1:0]         day_hour  [MAX_ENTRIES];
   int                        day_count;
   logic signed [PRICE_W-1:0] cheapest_price, dearest_price;
   logic [HOUR_W-1:0]         cheapest_hour, dearest_hour;
   logic [SLOTS_W-1:0]        slots_setting;
   logic [HOUR_W-1:0]         cutoff_setting;

   css_rsp_type slot_picks_due[$];

   int  cycles_run;
   int  mismatch_count;
   int  slots_checked;
   int  requests_sent;
   int  data_sets_sent;
   int  csr_writes;
   bit  sender_idles;

   cheapest_slot_selector DUT (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_data   (req_data),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycles_run++;
      if (cycles_run > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   task automatic flag_mismatch(input string what, input css_rsp_type want,
                                input css_rsp_type got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
         $display({"mismatch at cycle %0d (%s): expected hour %0d price %0d last %0b,",
                   " got hour %0d price %0d last %0b"},
                  cycles_run, what, want.slot_hour, $signed(want.slot_price),
                  want.end_of_run, got.slot_hour, $signed(got.slot_price),
                  got.end_of_run);
   endtask

   always @(posedge clock) begin : check_slots
      css_rsp_type want;
      if (!reset && rsp_strobe) begin
         if (slot_picks_due.size() == 0) begin
            flag_mismatch("no pick pending", '0, rsp_data);
         end else begin
            want = slot_picks_due.pop_front();
            slots_checked++;
            if (rsp_data.slot_hour !== want.slot_hour)
               flag_mismatch("slot_hour", want, rsp_data);
            if (rsp_data.slot_price !== want.slot_price)
               flag_mismatch("slot_price", want, rsp_data);
            if (rsp_data.end_of_run !== want.end_of_run)
               flag_mismatch("end_of_run", want, rsp_data);
         end
      end
   end

   // store the entry, track extremes, and on the final entry queue the picks
   task automatic predict_picks(input css_req_type item);
      logic signed [PRICE_W-1:0] price, prev_price, best_price;
      logic [HOUR_W-1:0]         prev_hour, best_hour;
      int                        picks, window, first_hour, cutoff;
      css_rsp_type               slot;
      price = item.price;
      if (day_count < MAX_ENTRIES) begin
         day_price[day_count] = price;
         day_hour[day_count]  = item.hour;
         if (day_count == 0) begin
            cheapest_price = price;
            cheapest_hour  = item.hour;
            dearest_price  = price;
            dearest_hour   = item.hour;
         end else if (price > dearest_price) begin
            dearest_price = price;
            dearest_hour  = item.hour;
         end else if (price < cheapest_price) begin
            cheapest_price = price;
            cheapest_hour  = item.hour;
         end
         day_count++;
      end
      if (!item.is_final)
         return;
      picks = slots_setting;
      if (picks < 1)
         picks = 1;
      if (picks > MAX_PICKS)
         picks = MAX_PICKS;
      first_hour = day_hour[0];
      cutoff     = cutoff_setting;
      if (first_hour <= cutoff)
         window = cutoff - first_hour;
      else
         window = HOURS_PER_DAY - first_hour + cutoff;
      if (window < 0)
         window = 0;
      if (window > day_count)
         window = day_count;
      prev_price = cheapest_price;
      prev_hour  = cheapest_hour;
      for (int n = 0; n < picks; n++) begin
         if (n > 0) begin
            best_price = dearest_price;
            best_hour  = dearest_hour;
            for (int j = 0; j < window; j++) begin
               if (day_price[j] > prev_price && day_price[j] < best_price) begin
                  best_price = day_price[j];
                  best_hour  = day_hour[j];
               end
            end
            prev_price = best_price;
            prev_hour  = best_hour;
         end
         slot.slot_hour  = prev_hour;
         slot.slot_price = prev_price;
         slot.end_of_run = (n == picks - 1);
         slot_picks_due.insert(slot_picks_due.size(), slot);
      end
      day_count = 0;
      data_sets_sent++;
   endtask

   task automatic send_entry(input logic [HOUR_W-1:0] hour,
                             input logic signed [PRICE_W-1:0] price, input bit last);
      css_req_type item;
      logic [31:0] word;
      int          gap;
      item.hour     = hour;
      item.price    = price;
      item.is_final = last;
      gap = 0;
      if (sender_idles && $urandom_range(99) < 30)
         gap = $urandom_range(1, 3);
      if (gap > 0) begin
         word = $urandom;
         start    <= 1'b0;
         req_data <= word[$bits(css_req_type)-1:0];
         repeat (gap) @(posedge clock);
      end
      start    <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      predict_picks(item);
      requests_sent++;
   endtask

   task automatic wait_drain();
      start <= 1'b0;
      while (slot_picks_due.size() != 0) @(posedge clock);
      repeat (IDLE_GUARD) @(posedge clock);
   endtask

   // write an unmapped index, then charge_slots, then cutoff_hour, valid held throughout
   task automatic configure(input logic [CSR_DATA_W-1:0] slots_value,
                            input logic [CSR_DATA_W-1:0] cutoff_value);
      logic [CSR_INDEX_W-1:0] index_list [3];
      logic [CSR_DATA_W-1:0]  value_list [3];
      logic [31:0]            word;
      word = $urandom;
      index_list[0] = word[5] ? CSR_UNMAPPED_HI : CSR_UNMAPPED_LO;
      value_list[0] = word[CSR_DATA_W-1:0];
      index_list[1] = CSR_CHARGE_SLOTS;
      value_list[1] = slots_value;
      index_list[2] = CSR_CUTOFF_HOUR;
      value_list[2] = cutoff_value;
      for (int k = 0; k < 3; k++) begin
         csr_valid <= 1'b1;
         csr_index <= index_list[k];
         csr_data  <= value_list[k];
         do @(posedge clock); while (!csr_ready);
         if (index_list[k] == CSR_CHARGE_SLOTS)
            slots_setting = value_list[k][SLOTS_W-1:0];
         else if (index_list[k] == CSR_CUTOFF_HOUR)
            cutoff_setting = value_list[k];
         csr_writes++;
      end
      csr_valid <= 1'b0;
   endtask

   function automatic logic signed [PRICE_W-1:0] draw_price(input price_mix_type mix);
      logic [31:0] word;
      word = $urandom;
      case (mix)
         PRICES_NARROW: return PRICE_W'(int'($urandom_range(12)) - 6);
         PRICES_EDGES: begin
            case (word[2:0])
               3'd0:    return PRICE_LOWEST;
               3'd1:    return PRICE_HIGHEST;
               3'd2:    return '0;
               3'd3:    return '1;
               3'd4:    return PRICE_W'(1);
               default: return word[PRICE_W-1:0];
            endcase
         end
         default: return word[PRICE_W-1:0];
      endcase
   endfunction

   task automatic send_data_set(input int length);
      price_mix_type     mix;
      logic [HOUR_W-1:0] hour;
      bit                sweep;
      mix   = price_mix_type'($urandom_range(2));
      sweep = ($urandom_range(99) < 80);
      hour  = HOUR_W'(($urandom_range(99) < 90) ? $urandom_range(23)
                                                 : $urandom_range(24, 31));
      for (int k = 0; k < length; k++) begin
         send_entry(hour, draw_price(mix), k == length - 1);
         hour = sweep ? HOUR_W'((int'(hour) + 1) % HOURS_PER_DAY)
                      : HOUR_W'($urandom_range(31));
      end
   endtask

   task automatic test_reset_settings();
      send_entry(5'd5, 24'sd300, 1'b0);
      send_entry(5'd6, 24'sd100, 1'b0);
      send_entry(5'd7, 24'sd100, 1'b0);
      send_entry(5'd8, 24'sd900, 1'b0);
      send_entry(5'd9, -24'sd40, 1'b1);
      wait_drain();
   endtask

   task automatic test_register_extremes();
      configure(5'd8, 5'd23);
      send_entry(5'd0, 24'sd50, 1'b0);
      send_entry(5'd1, 24'sd50, 1'b0);
      send_entry(5'd2, PRICE_LOWEST, 1'b0);
      send_entry(5'd3, PRICE_HIGHEST, 1'b0);
      send_entry(5'd4, PRICE_HIGHEST, 1'b0);
      send_entry(5'd5, 24'sd10, 1'b0);
      send_entry(5'd6, 24'sd10, 1'b0);
      send_entry(5'd7, 24'sd0, 1'b1);
      wait_drain();
      configure(5'd1, 5'd0);
      send_entry(5'd23, PRICE_HIGHEST, 1'b1);
      wait_drain();
      configure(5'd15, 5'd0);
      send_entry(5'd31, 24'sd5, 1'b0);
      send_entry(5'd24, PRICE_LOWEST, 1'b1);
      wait_drain();
      configure(5'd16, 5'd7);
      send_entry(5'd7, 24'sd1, 1'b0);
      send_entry(5'd7, 24'sd2, 1'b1);
      wait_drain();
      configure(5'd9, 5'd31);
      send_entry(5'd20, 24'sd4, 1'b0);
      send_entry(5'd21, 24'sd3, 1'b0);
      send_entry(5'd22, 24'sd3, 1'b1);
      wait_drain();
   endtask

   task automatic test_store_full();
      configure(5'd8, 5'd30);
      for (int k = 0; k < MAX_ENTRIES; k++)
         send_entry(HOUR_W'(k % HOURS_PER_DAY), draw_price(PRICES_NARROW), 1'b0);
      for (int k = 0; k < 6; k++)
         send_entry(HOUR_W'(k), k[0] ? PRICE_HIGHEST : PRICE_LOWEST, k == 5);
      wait_drain();
   endtask

   task automatic test_random_days();
      int random_items, phase_items, length, phase, pick;
      random_items = 0;
      phase        = 0;
      while (random_items < RANDOM_ITEMS) begin
         phase++;
         sender_idles = (phase % 4 != 2);
         if ($urandom_range(3) == 0)
            configure($urandom_range(1) ? 5'd8 : 5'd1, $urandom_range(1) ? 5'd23 : 5'd0);
         else
            configure(CSR_DATA_W'($urandom_range(31)), CSR_DATA_W'($urandom_range(31)));
         phase_items = 0;
         while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
            pick = $urandom_range(99);
            if (pick < 60)
               length = $urandom_range(1, 8);
            else if (pick < 90)
               length = $urandom_range(9, 24);
            else if (pick < 97)
               length = $urandom_range(25, 40);
            else
               length = $urandom_range(60, 70);
            send_data_set(length);
            length = (length > MAX_ENTRIES) ? MAX_ENTRIES : length;
            phase_items  += length;
            random_items += length;
         end
         wait_drain();
      end
      sender_idles = 1'b1;
   endtask

   initial begin
      reset          = 1'b1;
      start          = 1'b0;
      req_data       = '0;
      csr_valid      = 1'b0;
      csr_index      = '0;
      csr_data       = '0;
      cycles_run     = 0;
      mismatch_count = 0;
      slots_checked  = 0;
      requests_sent  = 0;
      data_sets_sent = 0;
      csr_writes     = 0;
      sender_idles   = 1'b1;
      day_count      = 0;
      cheapest_price = '0;
      cheapest_hour  = '0;
      dearest_price  = '0;
      dearest_hour   = '0;
      slots_setting  = CHARGE_SLOTS_RESET;
      cutoff_setting = CUTOFF_HOUR_RESET;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      repeat (IDLE_GUARD) @(posedge clock);

      test_reset_settings();
      test_register_extremes();
      test_store_full();
      test_random_days();

      wait_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("covered %0d price entries in %0d data sets, %0d slot picks checked",
               requests_sent, data_sets_sent, slots_checked);
      $display("register writes %0d, mismatches %0d, picks still pending %0d",
               csr_writes, mismatch_count, slot_picks_due.size());
      if (mismatch_count == 0 && slot_picks_due.size() == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule
